// ----- rtl/core/fsd_pkg.sv -----
// shared types, register codes and the per-channel quantizer for the rgb565 dither core
package fsd_pkg;

    typedef logic signed [7:0] err8_t;
    typedef logic signed [3:0] qerr_t;

    typedef struct packed {
        logic [5:0] level;
        qerr_t      err;
    } quant_t;

    // configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam int unsigned CH_NUM      = 3;
    localparam int unsigned ERR_W       = 8;
    localparam int unsigned LINE_W      = CH_NUM * ERR_W;
    localparam logic [11:0] WIDTH_RST   = 12'd2048;
    localparam logic [15:0] HEIGHT_RST  = 16'd1;

    // add the rounded sixteenths to the channel, clamp, truncate, measure the error
    function automatic quant_t quantize(input logic [7:0] pix, input logic signed [8:0] acc,
                                        input logic six_bit);
        logic [7:0]        mag;
        logic [3:0]        rnd;
        logic signed [9:0] sum;
        logic [7:0]        clamped;
        logic [7:0]        rep;
        logic signed [8:0] diff;
        quant_t            r;
        mag = acc[8] ? 8'(-acc) : acc[7:0];
        rnd = 4'((9'(mag) + 9'd8) >> 4);
        sum = $signed({2'b00, pix}) +
              (acc[8] ? -$signed({6'b0, rnd}) : $signed({6'b0, rnd}));
        if (sum < 10'sd0) begin
            clamped = 8'd0;
        end else if (sum > 10'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = sum[7:0];
        end
        if (six_bit) begin
            r.level = clamped[7:2];
            rep     = {clamped[7:2], clamped[7:6]};
        end else begin
            r.level = {1'b0, clamped[7:3]};
            rep     = {clamped[7:3], clamped[7:5]};
        end
        diff  = $signed({1'b0, clamped}) - $signed({1'b0, rep});
        r.err = diff[3:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/floyd_steinberg_rgb565_dither_core.sv -----
// floyd-steinberg dither core, rgb888 pixels in raster order to rgb565 words
//
// Takes one pixel per clock while the master side does not stall and gives one rgb565 word
// per pixel. The word passes the compute stage registers and then the output register.
// m_tlast marks the last pixel of a row and m_tuser the last pixel of the frame. The errors
// carried to the next row sit in a line memory of MAX_WIDTH entries with one read and one
// write port; the error for the next pixel in the row is resolved combinationally in the
// compute stage, which sets the one-pixel-per-clock rate. Writes that land on an entry while
// it is being read are forwarded. image_width and image_height must be written only while
// the core is idle; the core leaves this to the user. A zero counts as one and a width above
// MAX_WIDTH counts as MAX_WIDTH. The line memory has no reset and needs no clearing pass:
// the first row of a frame ignores it.
module floyd_steinberg_rgb565_dither_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // rgb565 output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel565 [15:0]
    output logic        m_tlast,
    output logic        m_tuser    // end_of_frame [0]
);
    import fsd_pkg::*;

    localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = (XW + 1 > 12) ? XW + 1 : 12;

    // configuration
    logic [11:0] width_reg;
    logic [15:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[11:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // position of the incoming pixel
    logic [XW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic [CW-1:0] w_nz, w_eff, col_ext, x0_ext;
    logic [15:0]   h_eff, y0;
    logic [XW-1:0] x0;
    logic          last_col0, last_row0;

    always_comb begin
        w_nz      = (width_reg == 12'd0) ? CW'(1) : CW'(width_reg);
        w_eff     = (w_nz > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_nz;
        col_ext   = CW'(col_reg);
        x0_ext    = (col_ext >= w_eff) ? w_eff - CW'(1) : col_ext;
        x0        = x0_ext[XW-1:0];
        last_col0 = (x0_ext == w_eff - CW'(1));
        h_eff     = (height_reg == 16'd0) ? 16'd1 : height_reg;
        y0        = (row_reg >= h_eff) ? h_eff - 16'd1 : row_reg;
        last_row0 = (y0 == h_eff - 16'd1);
        col_next  = last_col0 ? '0 : x0 + XW'(1);
        row_next  = last_col0 ? (last_row0 ? 16'd0 : y0 + 16'd1) : y0;
    end

    // handshake
    logic s1_valid_reg, m_tvalid_reg;
    logic s1_adv, s_accept;

    assign s1_adv   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // compute stage registers
    logic [23:0]   s1_pix_reg;
    logic [XW-1:0] s1_x_reg;
    logic          s1_first_col_reg, s1_last_col_reg, s1_last_row_reg, s1_y_nz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg       <= s_tdata;
            s1_x_reg         <= x0;
            s1_first_col_reg <= (x0 == '0);
            s1_last_col_reg  <= last_col0;
            s1_last_row_reg  <= last_row0;
            s1_y_nz_reg      <= (y0 != 16'd0);
        end
    end

    // carries within the row
    logic [LINE_W-1:0] right_carry_reg, pend_left_reg, pend_below_reg;
    logic [LINE_W-1:0] right_carry_next, pend_left_next, pend_below_next;
    logic [LINE_W-1:0] left_word, tail_word, below_word;
    logic [LINE_W-1:0] mem_q_reg, fwd_data_reg;
    logic              fwd_valid_reg;
    logic [15:0]       pixel565;

    assign below_word = fwd_valid_reg ? fwd_data_reg : mem_q_reg;

    always_comb begin
        err8_t             rc, plb, pb, blw, e8;
        logic signed [8:0] acc;
        quant_t            qr;
        logic [5:0]        lvl [CH_NUM];
        for (int c = 0; c < CH_NUM; c++) begin
            rc  = s1_first_col_reg ? 8'sd0 : $signed(right_carry_reg[8*c +: 8]);
            plb = s1_first_col_reg ? 8'sd0 : $signed(pend_left_reg[8*c +: 8]);
            pb  = s1_first_col_reg ? 8'sd0 : $signed(pend_below_reg[8*c +: 8]);
            blw = s1_y_nz_reg ? $signed(below_word[8*c +: 8]) : 8'sd0;
            acc = 9'(rc) + 9'(blw);
            qr  = quantize(s1_pix_reg[8*c +: 8], acc, c == 1);
            lvl[c] = qr.level;
            e8  = 8'(qr.err);
            right_carry_next[8*c +: 8] = s1_last_col_reg ? 8'sd0 : 8'(e8 * 8'sd7);
            left_word[8*c +: 8]        = 8'(plb + 8'(e8 * 8'sd3));
            tail_word[8*c +: 8]        = 8'(pb + 8'(e8 * 8'sd5));
            pend_below_next[8*c +: 8]  = s1_last_col_reg ? 8'sd0 : e8;
        end
        pend_left_next = s1_last_col_reg ? '0 : tail_word;
        pixel565 = {lvl[0][4:0], lvl[1], lvl[2][4:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_carry_reg <= '0;
            pend_left_reg   <= '0;
            pend_below_reg  <= '0;
        end else if (s1_adv) begin
            right_carry_reg <= right_carry_next;
            if (!s1_last_row_reg) begin
                pend_left_reg  <= pend_left_next;
                pend_below_reg <= pend_below_next;
            end else if (s1_first_col_reg) begin
                // a last row still starts from zero carries
                pend_left_reg  <= '0;
                pend_below_reg <= '0;
            end
        end
    end

    // line memory writes: the left neighbor's entry goes straight in, the last column's
    // entry waits in a tail register for a free write slot
    logic          main_we, tail_set, tail_flush;
    logic [XW-1:0] main_addr;
    logic          tail_valid_reg;
    logic [XW-1:0] tail_addr_reg;
    logic [LINE_W-1:0] tail_data_reg;

    assign main_we    = s1_adv && !s1_last_row_reg && !s1_first_col_reg;
    assign main_addr  = s1_x_reg - XW'(1);
    assign tail_set   = s1_adv && !s1_last_row_reg && s1_last_col_reg;
    assign tail_flush = tail_valid_reg && !main_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_valid_reg <= 1'b0;
        end else if (tail_set) begin
            tail_valid_reg <= 1'b1;
        end else if (tail_flush) begin
            tail_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tail_set) begin
            tail_addr_reg <= s1_x_reg;
            tail_data_reg <= tail_word;
        end
    end

    logic [LINE_W-1:0] err_mem [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        if (main_we) begin
            err_mem[main_addr] <= left_word;
        end else if (tail_flush) begin
            err_mem[tail_addr_reg] <= tail_data_reg;
        end
        if (s_accept) begin
            mem_q_reg <= err_mem[x0];
        end
    end

    // newest write to the entry being read wins over the memory's old data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_valid_reg <= (tail_set && s1_x_reg == x0) || (main_we && main_addr == x0) ||
                             (tail_valid_reg && tail_addr_reg == x0);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (tail_set && s1_x_reg == x0) begin
                fwd_data_reg <= tail_word;
            end else if (main_we && main_addr == x0) begin
                fwd_data_reg <= left_word;
            end else begin
                fwd_data_reg <= tail_data_reg;
            end
        end
    end

    // output register
    logic [15:0] m_tdata_reg;
    logic        m_tlast_reg, m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_tdata_reg <= pixel565;
            m_tlast_reg <= s1_last_col_reg;
            m_tuser_reg <= s1_last_col_reg && s1_last_row_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // a pending tail entry is never dropped by a new one
    a_tail_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_set && tail_valid_reg |-> !main_we)
        else $error("tail entry overwritten before it was written back");

    // a pixel only enters a full compute stage when that stage moves on
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s1_valid_reg |-> s1_adv)
        else $error("compute stage overrun");

    // frame end only on a row end
    a_frame_on_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame without end of row");

endmodule
